>>> rtl/rsmd_pkg.sv
package rsmd_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] buffer_level;
  } in_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       packet_end;
    logic [2:0] status;
    logic [3:0] frame_count;
  } out_t;

  typedef struct packed {
    logic [15:0] byte_position;
    logic [17:0] header_end;
    logic        extension_present;
    logic [7:0]  extension_count_high;
    logic [2:0]  packet_verdict;
    logic [3:0]  frames_in_packet;
  } state_t;

  localparam logic [2:0] STATUS_DELIVERED  = 3'd0;
  localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
  localparam logic [2:0] STATUS_FRAGMENTED = 3'd2;
  localparam logic [2:0] STATUS_EMPTY      = 3'd3;
  localparam logic [2:0] STATUS_DROPPED    = 3'd4;

  localparam logic [17:0] RTP_FIXED_LEN          = 18'd12;
  localparam logic [17:0] HEADER_END_UNREACHABLE = 18'h3FFFF;
  localparam logic [15:0] POSITION_MAX           = 16'hFFFF;
  localparam logic [15:0] THRESHOLD_RESET        = 16'd8192;

  localparam state_t STATE_RESET = '{
    byte_position:        16'd0,
    header_end:           RTP_FIXED_LEN,
    extension_present:    1'b0,
    extension_count_high: 8'd0,
    packet_verdict:       STATUS_DELIVERED,
    frames_in_packet:     4'd0
  };

endpackage

>>> rtl/rsmd_step.sv
module rsmd_step
  import rsmd_pkg::*;
(
  input  state_t      cur,
  input  in_t         item,
  input  logic [15:0] threshold,
  output state_t      nxt,
  output logic        emit,
  output out_t        result
);

  logic [15:0] pos;
  logic [17:0] pos_wide;
  logic [18:0] hend_p2;
  logic [18:0] hend_p3;
  logic [15:0] words;
  logic [18:0] ext_end;
  logic        forward;
  logic [2:0]  status;

  always_comb begin
    pos      = cur.byte_position;
    pos_wide = {2'b00, pos};
    hend_p2  = {1'b0, cur.header_end} + 19'd2;
    hend_p3  = {1'b0, cur.header_end} + 19'd3;
    words    = {cur.extension_count_high, item.data_byte};
    ext_end  = {1'b0, cur.header_end} + 19'd4 + {1'b0, words, 2'b00};
    forward  = 1'b0;
    nxt      = cur;

    if (pos == 16'd0) begin
      nxt.header_end        = RTP_FIXED_LEN + {12'd0, item.data_byte[3:0], 2'b00};
      nxt.extension_present = item.data_byte[4];
    end else if (cur.extension_present && ({3'd0, pos} == hend_p2)) begin
      nxt.extension_count_high = item.data_byte;
    end else if (cur.extension_present && ({3'd0, pos} == hend_p3)) begin
      if (ext_end >= 19'h0FFFF) begin
        nxt.header_end = HEADER_END_UNREACHABLE;
      end else begin
        nxt.header_end = ext_end[17:0];
      end
      nxt.extension_present = 1'b0;
    end else if (!cur.extension_present && (pos_wide == cur.header_end)) begin
      nxt.frames_in_packet = item.data_byte[3:0];
      if (item.data_byte[7:5] != 3'd0) begin
        nxt.packet_verdict = STATUS_FRAGMENTED;
      end else if (item.buffer_level >= threshold) begin
        nxt.packet_verdict = STATUS_DROPPED;
      end else begin
        nxt.packet_verdict = STATUS_DELIVERED;
      end
    end else if (!cur.extension_present && (pos_wide > cur.header_end)) begin
      forward = (cur.packet_verdict == STATUS_DELIVERED);
    end

    // outcome uses the state as updated by this byte
    status = STATUS_DELIVERED;
    if (item.last_byte) begin
      if (nxt.extension_present || (pos_wide < nxt.header_end)) begin
        status = STATUS_TOO_SHORT;
      end else if (pos_wide == nxt.header_end) begin
        status = (nxt.packet_verdict == STATUS_FRAGMENTED) ? STATUS_FRAGMENTED : STATUS_EMPTY;
      end else begin
        status = nxt.packet_verdict;
      end
    end

    result.payload_valid = forward;
    result.payload_byte  = forward ? item.data_byte : 8'd0;
    result.packet_end    = item.last_byte;
    result.status        = status;
    result.frame_count   = nxt.frames_in_packet;
    emit                 = forward || item.last_byte;

    if (item.last_byte) begin
      nxt = STATE_RESET;
    end else if (pos < POSITION_MAX) begin
      nxt.byte_position = pos + 16'd1;
    end
  end

endmodule

>>> rtl/rtp_sbc_media_packet_deframer.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------
// input    | in        | in_valid / in_ready    | in_data  (rsmd_pkg::in_t)
// result   | out       | out_valid / out_ready  | out_data (rsmd_pkg::out_t)
// config   | in        | cfg_we                 | cfg_wdata (threshold)
//
// one byte per cycle sustained while results are taken; each result passes the input
// register, then the result register
// synchronous reset clears all packet state and loads the threshold with 8192
// a held result stalls the input only when the next byte also makes a result
module rtp_sbc_media_packet_deframer
  import rsmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        s1_valid;
  in_t         s1_data;
  state_t      st;
  state_t      st_next;
  logic [15:0] threshold;
  logic        emit;
  out_t        result;
  logic        out_free;
  logic        s1_adv;

  rsmd_step u_step (
    .cur       (st),
    .item      (s1_data),
    .threshold (threshold),
    .nxt       (st_next),
    .emit      (emit),
    .result    (result)
  );

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!emit || out_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      st        <= STATE_RESET;
      threshold <= THRESHOLD_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        st <= st_next;
      end
      if (out_free) begin
        out_valid <= s1_adv && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
    if (s1_adv && emit) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/rsmd_checker.sv
module rsmd_checker
  import rsmd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // payload bytes only travel in packets that are being delivered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.payload_valid |-> out_data.status == STATUS_DELIVERED)
    else $error("payload transfer with nonzero status");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.packet_end |-> out_data.status == STATUS_DELIVERED)
    else $error("status set away from packet end");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
    else $error("payload byte set without payload");

  // every result is a payload byte, a packet end, or both
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.payload_valid || out_data.packet_end)
    else $error("empty result transfer");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind rtp_sbc_media_packet_deframer rsmd_checker u_rsmd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/rtp_sbc_media_packet_deframer_test.sv
module rtp_sbc_media_packet_deframer_test;
  import rsmd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  rtp_sbc_media_packet_deframer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_t packet_bytes[$];
  out_t deframer_outputs[$];

  // shadow of the deframer state
  logic [15:0] rx_pos;
  logic [17:0] hdr_end;
  logic ext_pending;
  logic [7:0] ext_words_hi;
  logic [2:0] verdict;
  logic [3:0] sbc_frames;
  logic [15:0] threshold_copy;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int stall_cycles = 0;
  int bytes_queued = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int payload_checked = 0;
  int mismatches = 0;
  int status_seen[5];
  out_t want_out;

  task automatic clear_packet_state();
    rx_pos = '0;
    hdr_end = RTP_FIXED_LEN;
    ext_pending = 1'b0;
    ext_words_hi = '0;
    verdict = STATUS_DELIVERED;
    sbc_frames = '0;
  endtask

  task automatic deframe_byte(input in_t item);
    int unsigned b;
    int unsigned pos;
    int unsigned words;
    int unsigned ext_end;
    out_t res;
    bit produce;
    b = item.data_byte;
    pos = rx_pos;
    res = '0;
    produce = 1'b0;
    if (pos == 0) begin
      hdr_end = 18'(RTP_FIXED_LEN + 4 * (b & 'hF));
      ext_pending = b[4];
    end else if (ext_pending && pos == hdr_end + 2) begin
      ext_words_hi = b[7:0];
    end else if (ext_pending && pos == hdr_end + 3) begin
      words = {ext_words_hi, b[7:0]};
      ext_end = hdr_end + 4 + 4 * words;
      if (ext_end >= POSITION_MAX)
        ext_end = HEADER_END_UNREACHABLE;
      hdr_end = 18'(ext_end);
      ext_pending = 1'b0;
    end else if (!ext_pending && pos == hdr_end) begin
      sbc_frames = b[3:0];
      if (b[7:5] != 3'd0)
        verdict = STATUS_FRAGMENTED;
      else if (item.buffer_level >= threshold_copy)
        verdict = STATUS_DROPPED;
      else
        verdict = STATUS_DELIVERED;
    end else if (!ext_pending && pos > hdr_end) begin
      if (verdict == STATUS_DELIVERED) begin
        res.payload_valid = 1'b1;
        res.payload_byte = b[7:0];
        produce = 1'b1;
      end
    end
    res.frame_count = sbc_frames;
    if (item.last_byte) begin
      produce = 1'b1;
      res.packet_end = 1'b1;
      if (ext_pending || pos < hdr_end)
        res.status = STATUS_TOO_SHORT;
      else if (pos == hdr_end)
        res.status = (verdict == STATUS_FRAGMENTED) ? STATUS_FRAGMENTED : STATUS_EMPTY;
      else
        res.status = verdict;
      clear_packet_state();
    end else if (pos < POSITION_MAX) begin
      rx_pos = 16'(pos + 1);
    end
    if (produce)
      deframer_outputs.push_back(res);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // byte source
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (packet_bytes.size() > 0) begin
          in_data <= packet_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result sink and compare
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframer_outputs.size() == 0) begin
          $error("result with nothing pending: %p", out_data);
          mismatches++;
        end else begin
          want_out = deframer_outputs.pop_front();
          check_field("payload_valid", want_out.payload_valid, out_data.payload_valid);
          check_field("payload_byte", want_out.payload_byte, out_data.payload_byte);
          check_field("packet_end", want_out.packet_end, out_data.packet_end);
          check_field("status", want_out.status, out_data.status);
          check_field("frame_count", want_out.frame_count, out_data.frame_count);
          results_checked++;
          if (want_out.payload_valid)
            payload_checked++;
          if (want_out.packet_end)
            status_seen[want_out.status]++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("transfers stopped for %0d cycles", STALL_LIMIT);
        $display("rtp_sbc_media_packet_deframer regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return (threshold_copy == 16'd0) ? 16'd0 :
                16'($urandom_range(0, threshold_copy - 1));
      2: return threshold_copy;
      3: return 16'($urandom_range(threshold_copy, 16'hFFFF));
      default: return (threshold_copy == 16'd0) ? 16'd0 : threshold_copy - 16'd1;
    endcase
  endfunction

  // keep_len of 0 keeps the whole packet, otherwise it is cut after keep_len bytes
  task automatic queue_packet(input int csrc, input bit ext, input int ext_words,
                              input logic [7:0] sbc_hdr, input int payload_len,
                              input int keep_len, input logic [15:0] level);
    logic [7:0] pkt[$];
    logic [7:0] head_byte;
    int hdr_pos;
    in_t item;
    head_byte = 8'($urandom);
    head_byte[4] = ext;
    head_byte[3:0] = 4'(csrc);
    pkt.push_back(head_byte);
    repeat (11 + 4 * csrc) pkt.push_back(8'($urandom));
    if (ext) begin
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back(ext_words[15:8]);
      pkt.push_back(ext_words[7:0]);
      repeat (4 * ext_words) pkt.push_back(8'($urandom));
    end
    hdr_pos = pkt.size();
    pkt.push_back(sbc_hdr);
    repeat (payload_len) pkt.push_back(8'($urandom));
    if (keep_len > 0)
      while (pkt.size() > keep_len) void'(pkt.pop_back());
    foreach (pkt[i]) begin
      item.data_byte = pkt[i];
      item.last_byte = (i == pkt.size() - 1);
      item.buffer_level = (i == hdr_pos) ? level : 16'($urandom);
      packet_bytes.push_back(item);
    end
    bytes_queued += pkt.size();
  endtask

  task automatic queue_noise(input int len);
    in_t item;
    for (int i = 0; i < len; i++) begin
      item.data_byte = 8'($urandom);
      item.last_byte = (i == len - 1);
      item.buffer_level = 16'($urandom);
      packet_bytes.push_back(item);
    end
    bytes_queued += len;
  endtask

  task automatic queue_random_traffic(input int n_bytes);
    int stop_at;
    int csrc;
    bit ext;
    int words;
    logic [7:0] sbc_hdr;
    int payload_len;
    int full_len;
    int kind;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      kind = $urandom_range(0, 19);
      csrc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      ext = ($urandom_range(0, 3) == 0);
      words = $urandom_range(0, 3);
      sbc_hdr = 8'($urandom);
      if ($urandom_range(0, 4) != 0)
        sbc_hdr[7:5] = 3'd0;
      payload_len = $urandom_range(0, 16);
      full_len = 12 + 4 * csrc + (ext ? 4 + 4 * words : 0) + 1 + payload_len;
      if (kind < 14)
        queue_packet(csrc, ext, words, sbc_hdr, payload_len, 0, pick_level());
      else if (kind < 17)
        queue_packet(csrc, ext, words, sbc_hdr, payload_len,
                     $urandom_range(1, full_len), pick_level());
      else
        queue_noise($urandom_range(1, 24));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (packet_bytes.size() != 0 || in_valid || deframer_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_copy = value;
  endtask

  initial begin
    clear_packet_state();
    threshold_copy = THRESHOLD_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    in_idle_pct = 15;
    out_idle_pct = 15;
    // delivered and dropped, csrc and extension extremes, threshold edges
    queue_packet(0, 1'b0, 0, 8'h05, 4, 0, 16'd0);
    queue_packet(15, 1'b1, 0, 8'h0F, 3, 0, THRESHOLD_RESET - 16'd1);
    queue_packet(0, 1'b1, 2, 8'h00, 2, 0, THRESHOLD_RESET);
    queue_packet(2, 1'b0, 0, 8'h10, 2, 0, 16'hFFFF);
    // fragmented on each flag bit, one ending on the media header
    queue_packet(0, 1'b0, 0, 8'h20, 2, 0, 16'd0);
    queue_packet(1, 1'b0, 0, 8'h41, 2, 0, 16'hFFFF);
    queue_packet(0, 1'b0, 0, 8'hE1, 0, 0, 16'd0);
    // empty payload, with buffer level below and above the threshold
    queue_packet(0, 1'b0, 0, 8'h03, 0, 0, 16'd0);
    queue_packet(0, 1'b1, 1, 8'h03, 0, 0, 16'hFFFF);
    // header never reached
    queue_packet(0, 1'b0, 0, 8'h01, 4, 1, 16'd0);
    queue_packet(3, 1'b0, 0, 8'h01, 4, 5, 16'd0);
    queue_packet(0, 1'b1, 1, 8'h01, 4, 15, 16'd0);
    queue_packet(0, 1'b1, 1, 8'h01, 4, 16, 16'd0);
    queue_packet(0, 1'b0, 0, 8'h81, 4, 12, 16'd0);
    // extension too large to reach
    queue_packet(1, 1'b1, 16379, 8'h01, 4, 40, 16'd0);
    queue_packet(0, 1'b1, 16'hFFFF, 8'h01, 4, 30, 16'd0);
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_threshold(16'd0);
        1: write_threshold(16'hFFFF);
        default: write_threshold(16'($urandom));
      endcase
      @(negedge clk);
      if (phase == 4) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = $urandom_range(0, 2) * 12;
        out_idle_pct = $urandom_range(0, 2) * 12;
      end
      queue_random_traffic(PHASE_BYTES);
      wait_idle();
    end

    $display("%0d bytes sent, %0d results checked, %0d of them payload bytes",
             bytes_sent, results_checked, payload_checked);
    $display("packet outcomes: delivered %0d, too short %0d, fragmented %0d, empty %0d, dropped %0d",
             status_seen[STATUS_DELIVERED], status_seen[STATUS_TOO_SHORT],
             status_seen[STATUS_FRAGMENTED], status_seen[STATUS_EMPTY],
             status_seen[STATUS_DROPPED]);
    if (mismatches == 0 && deframer_outputs.size() == 0)
      $display("rtp_sbc_media_packet_deframer regression: pass");
    else
      $display("rtp_sbc_media_packet_deframer regression: fail");
    $finish;
  end

endmodule
